### sv/kwc_pkg.sv
// Package for the Kaiser window coefficient block.
// Holds register indexes, fixed-point constants, multiplier shift codes and the Horner table.
// No dependencies.
package kwc_pkg;

   localparam int unsigned KWC_MAX_LENGTH   = 4096;
   localparam int unsigned KWC_SERIES_TERMS = 48;

   localparam int BETA_W  = 16;
   localparam int LEN_W   = 13;
   localparam int INDEX_W = 12;
   localparam int COEF_W  = 18;

   // register indexes on the csr port
   localparam logic REG_BETA = 1'b0;
   localparam logic REG_LEN  = 1'b1;

   // right shift applied after a 64x64 product
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_28 = 2'd1;
   localparam logic [1:0] SH_29 = 2'd2;
   localparam logic [1:0] SH_32 = 2'd3;

   localparam logic [63:0] Q29_ONE   = 64'd536870912;
   localparam logic [63:0] C_A6      = 64'd112743;
   localparam logic [63:0] POLY_MAX  = 64'd1610612736;   // 3.0 in Q.29
   localparam logic [63:0] Q20_ONE   = 64'd1048576;
   // ceil(2^33 / 3): (x * RECIP3) >> 33 equals x / 3 for any x below 2^32
   localparam logic [63:0] RECIP3    = 64'hAAAA_AAAB;
   localparam logic [COEF_W-1:0] COEF_ONE = 18'd131072;

   // Horner coefficients after the innermost one, in Q.29
   function automatic logic [63:0] kwc_horner(input logic [2:0] step);
      logic [63:0] c;
      case (step)
         3'd0: c = 64'd2117634;
         3'd1: c = 64'd23862785;
         3'd2: c = 64'd169858762;
         3'd3: c = 64'd679474993;
         3'd4: c = 64'd1207959391;
         default: c = Q29_ONE;
      endcase
      return c;
   endfunction

endpackage

### sv/kaiser_window_coefficient.sv
// Kaiser window coefficient generator: top level with sequencer, shared multiplier,
// divider and square-root step. Depends on kwc_pkg.
//
// Usage: raise start with req_sample_index while busy is low; the request is taken at
// that edge. One result follows on rsp_coefficient / rsp_index_error, marked by a
// one-cycle rsp_valid strobe; the receiver must take it in that cycle.
// csr_we writes beta (index 0, Q5.11) or the window length (index 1);
// write only while busy is low and no result is pending.
// An out-of-range index or a length of one answers in the next cycle with busy low.
// Otherwise busy stays high for the whole computation: a square root, 64-bit divisions
// and products on the shared multiplier, which forms each 64x64 product from 32x32
// partial products. I0 of an argument up to 3.0 is a polynomial (divide by three as a
// reciprocal product); above 3.0 it is a series of SERIES_TERMS terms, each term after
// the first needing a division and a product. Each request takes two I0 evaluations,
// setup and a final division.
// Reset restores beta = 5.0 and length 64 and returns the sequencer to idle.
// The receiver cannot stall; nothing is held back.
module kaiser_window_coefficient #(
   parameter int unsigned MAX_LENGTH   = kwc_pkg::KWC_MAX_LENGTH,
   parameter int unsigned SERIES_TERMS = kwc_pkg::KWC_SERIES_TERMS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [kwc_pkg::INDEX_W-1:0]  req_sample_index,
   output logic                         rsp_valid,
   output logic [kwc_pkg::COEF_W-1:0]   rsp_coefficient,
   output logic                         rsp_index_error,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [kwc_pkg::BETA_W-1:0]   csr_wdata
);
   import kwc_pkg::*;

   localparam int KW = $clog2(SERIES_TERMS);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQV   = 4'd1;
   localparam logic [3:0] ST_SQRT  = 4'd2;
   localparam logic [3:0] ST_SDIV  = 4'd3;
   localparam logic [3:0] ST_XMUL  = 4'd4;
   localparam logic [3:0] ST_I0    = 4'd5;
   localparam logic [3:0] ST_PQ    = 4'd6;
   localparam logic [3:0] ST_PU    = 4'd7;
   localparam logic [3:0] ST_PH    = 4'd8;
   localparam logic [3:0] ST_SY    = 4'd9;
   localparam logic [3:0] ST_SD    = 4'd10;
   localparam logic [3:0] ST_ST    = 4'd11;
   localparam logic [3:0] ST_I0END = 4'd12;
   localparam logic [3:0] ST_FDIV  = 4'd13;

   // configuration
   logic [BETA_W-1:0] beta_ff, beta_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   // sequencer and algorithm registers
   logic [3:0]         state_ff, state_in;
   logic [LEN_W-1:0]   d_ff, d_in;
   logic [63:0]        x_ff, x_in;
   logic [63:0]        u_ff, u_in;
   logic [63:0]        y_ff, y_in;
   logic [63:0]        t_ff, t_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        i0_ff, i0_in;
   logic [63:0]        ix_ff, ix_in;
   logic [2:0]         h_ff, h_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               second_ff, second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;
   logic               err_ff, err_in;

   // square-root step
   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;

   // shared multiplier
   logic [63:0]  mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [1:0]   mul_sh_ff, mul_sh_in;
   logic [127:0] mul_acc_ff, mul_acc_in;
   logic [1:0]   mul_cnt_ff, mul_cnt_in;
   logic         mul_busy_ff, mul_busy_in;

   // shared divider
   logic [63:0] div_num_ff, div_num_in, div_den_ff, div_den_in;
   logic [63:0] div_rem_ff, div_rem_in, div_quo_ff, div_quo_in;
   logic [6:0]  div_cnt_ff, div_cnt_in;
   logic        div_wrap_ff, div_wrap_in;
   logic        div_busy_ff, div_busy_in;

   // combinational helpers
   logic [63:0]  mul_res;
   logic [31:0]  pp_a, pp_b;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [64:0]  div_t;
   logic [65:0]  sub_a, sub_b, sub_d;
   logic         sub_ge;
   logic [63:0]  sq_rb;
   logic [LEN_W-1:0] len_eff;
   logic [KW-1:0]    k_nx;
   logic [2*KW-1:0]  kk_nx;
   logic [64:0]      sat_sum;
   logic [63:0]      p_new;

   logic             go_mul, go_div, go_wrap;
   logic [63:0]      go_a, go_b, go_num, go_den;
   logic [1:0]       go_sh;

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_index_error = err_ff;

   assign len_eff = ({4'b0, len_ff} > 17'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_ff;
   assign k_nx    = k_ff + KW'(1);
   assign kk_nx   = {{KW{1'b0}}, k_nx} * {{KW{1'b0}}, k_nx};
   assign sq_rb   = sq_res_ff + sq_bit_ff;

   // product finish: shift and saturate to 64 bits
   always_comb begin
      case (mul_sh_ff)
         SH_0:    mul_res = (|mul_acc_ff[127:64]) ? '1 : mul_acc_ff[63:0];
         SH_28:   mul_res = (|mul_acc_ff[127:92]) ? '1 : mul_acc_ff[91:28];
         SH_29:   mul_res = (|mul_acc_ff[127:93]) ? '1 : mul_acc_ff[92:29];
         default: mul_res = (|mul_acc_ff[127:96]) ? '1 : mul_acc_ff[95:32];
      endcase
   end

   // one 32x32 partial product per cycle
   always_comb begin
      pp_a = (mul_cnt_ff[1]) ? mul_a_ff[63:32] : mul_a_ff[31:0];
      pp_b = (mul_cnt_ff[0]) ? mul_b_ff[63:32] : mul_b_ff[31:0];
      pp   = 64'(pp_a) * 64'(pp_b);
      case (mul_cnt_ff)
         2'd0:    pp_sh = {64'b0, pp};
         2'd3:    pp_sh = {pp, 64'b0};
         default: pp_sh = {32'b0, pp, 32'b0};
      endcase
   end

   // shared subtractor: square-root step or divider step
   always_comb begin
      div_t = div_wrap_ff ? {1'b0, div_rem_ff[62:0], 1'b0} : {div_rem_ff, div_num_ff[63]};
      if (state_ff == ST_SQRT) begin
         sub_a = {2'b0, sq_v_ff};
         sub_b = {2'b0, sq_rb};
      end else begin
         sub_a = {1'b0, div_t};
         sub_b = {2'b0, div_den_ff};
      end
      sub_d  = sub_a - sub_b;
      sub_ge = ~sub_d[65];
   end

   always_comb begin
      beta_in      = beta_ff;
      len_in       = len_ff;
      state_in     = state_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      u_in         = u_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      i0_in        = i0_ff;
      ix_in        = ix_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      second_in    = second_ff;
      rsp_valid_in = 1'b0;
      coef_in      = coef_ff;
      err_in       = err_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      go_mul       = 1'b0;
      go_a         = '0;
      go_b         = '0;
      go_sh        = SH_0;
      go_div       = 1'b0;
      go_wrap      = 1'b0;
      go_num       = '0;
      go_den       = '0;
      sat_sum      = {1'b0, sum_ff} + {1'b0, mul_res};
      p_new        = kwc_horner(h_ff) + mul_res;

      if (csr_we) begin
         unique case (csr_index)
            REG_BETA: beta_in = csr_wdata;
            REG_LEN:  len_in  = csr_wdata[LEN_W-1:0];
            default:  beta_in = beta_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ({1'b0, req_sample_index} >= len_eff) begin
                  coef_in      = '0;
                  err_in       = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (len_eff == LEN_W'(1)) begin
                  coef_in      = COEF_ONE;
                  err_in       = 1'b0;
                  rsp_valid_in = 1'b1;
               end else begin
                  d_in     = len_eff - LEN_W'(1);
                  go_mul   = 1'b1;
                  go_a     = 64'(req_sample_index);
                  go_b     = 64'(len_eff - LEN_W'(1) - {1'b0, req_sample_index});
                  go_sh    = SH_0;
                  state_in = ST_SQV;
               end
            end
         end
         ST_SQV: begin
            if (!mul_busy_ff) begin
               sq_v_in   = {mul_res[25:0], 38'b0};
               sq_res_in = '0;
               sq_bit_in = 64'd1 << 62;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_bit_in = sq_bit_ff >> 2;
            if (sub_ge) begin
               sq_v_in   = sub_d[63:0];
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            if (sq_bit_ff == 64'd1) begin
               go_div   = 1'b1;
               go_num   = sq_res_in;
               go_den   = 64'(d_ff);
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (!div_busy_ff) begin
               go_mul   = 1'b1;
               go_a     = 64'(beta_ff);
               go_b     = div_quo_ff;
               go_sh    = SH_0;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            if (!mul_busy_ff) begin
               x_in      = mul_res;
               second_in = 1'b0;
               state_in  = ST_I0;
            end
         end
         ST_I0: begin
            if (x_ff <= POLY_MAX) begin
               // divide by three: product with the reciprocal, one more shift below
               go_mul   = 1'b1;
               go_a     = x_ff;
               go_b     = RECIP3;
               go_sh    = SH_32;
               state_in = ST_PQ;
            end else begin
               go_mul   = 1'b1;
               go_a     = x_ff;
               go_b     = x_ff;
               go_sh    = SH_28;
               state_in = ST_SY;
            end
         end
         ST_PQ: begin
            if (!mul_busy_ff) begin
               go_mul   = 1'b1;
               go_a     = mul_res >> 1;
               go_b     = mul_res >> 1;
               go_sh    = SH_29;
               state_in = ST_PU;
            end
         end
         ST_PU: begin
            if (!mul_busy_ff) begin
               u_in     = mul_res;
               h_in     = '0;
               go_mul   = 1'b1;
               go_a     = mul_res;
               go_b     = C_A6;
               go_sh    = SH_29;
               state_in = ST_PH;
            end
         end
         ST_PH: begin
            if (!mul_busy_ff) begin
               if (h_ff == 3'd5) begin
                  i0_in    = p_new >> 9;
                  state_in = ST_I0END;
               end else begin
                  h_in   = h_ff + 3'd1;
                  go_mul = 1'b1;
                  go_a   = u_ff;
                  go_b   = p_new;
                  go_sh  = SH_29;
               end
            end
         end
         ST_SY: begin
            if (!mul_busy_ff) begin
               y_in     = mul_res;
               t_in     = Q20_ONE;
               sum_in   = Q20_ONE;
               k_in     = KW'(1);
               go_div   = 1'b1;
               go_num   = mul_res;
               go_den   = 64'd1;
               state_in = ST_SD;
            end
         end
         ST_SD: begin
            if (!div_busy_ff) begin
               go_mul   = 1'b1;
               go_a     = t_ff;
               go_b     = div_quo_ff;
               go_sh    = SH_32;
               state_in = ST_ST;
            end
         end
         ST_ST: begin
            if (!mul_busy_ff) begin
               t_in   = mul_res;
               sum_in = sat_sum[64] ? '1 : sat_sum[63:0];
               if (k_ff == KW'(SERIES_TERMS - 1)) begin
                  i0_in    = sat_sum[64] ? '1 : sat_sum[63:0];
                  state_in = ST_I0END;
               end else begin
                  k_in     = k_nx;
                  go_div   = 1'b1;
                  go_num   = y_ff;
                  go_den   = 64'(kk_nx);
                  state_in = ST_SD;
               end
            end
         end
         ST_I0END: begin
            if (!second_ff) begin
               ix_in     = i0_ff;
               second_in = 1'b1;
               x_in      = {30'b0, beta_ff, 18'b0};
               state_in  = ST_I0;
            end else if (ix_ff >= i0_ff) begin
               coef_in      = COEF_ONE;
               err_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               go_div   = 1'b1;
               go_wrap  = 1'b1;
               go_num   = ix_ff;
               go_den   = i0_ff;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (!div_busy_ff) begin
               coef_in      = div_quo_ff[COEF_W-1:0];
               err_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // multiplier: four partial products, then the result is ready
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      mul_sh_in   = mul_sh_ff;
      mul_acc_in  = mul_acc_ff;
      mul_cnt_in  = mul_cnt_ff;
      mul_busy_in = mul_busy_ff;
      if (go_mul) begin
         mul_a_in    = go_a;
         mul_b_in    = go_b;
         mul_sh_in   = go_sh;
         mul_acc_in  = '0;
         mul_cnt_in  = '0;
         mul_busy_in = 1'b1;
      end else if (mul_busy_ff) begin
         mul_acc_in = mul_acc_ff + pp_sh;
         mul_cnt_in = mul_cnt_ff + 2'd1;
         if (mul_cnt_ff == 2'd3) begin
            mul_busy_in = 1'b0;
         end
      end

      // divider: restoring, one quotient bit per cycle
      div_num_in  = div_num_ff;
      div_den_in  = div_den_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_cnt_in  = div_cnt_ff;
      div_wrap_in = div_wrap_ff;
      div_busy_in = div_busy_ff;
      if (go_div) begin
         div_den_in  = go_den;
         div_wrap_in = go_wrap;
         div_quo_in  = '0;
         div_busy_in = 1'b1;
         if (go_wrap) begin
            div_rem_in = go_num;
            div_num_in = '0;
            div_cnt_in = 7'd17;
         end else begin
            div_rem_in = '0;
            div_num_in = go_num;
            div_cnt_in = 7'd64;
         end
      end else if (div_busy_ff) begin
         div_rem_in = sub_ge ? sub_d[63:0] : div_t[63:0];
         div_quo_in = {div_quo_ff[62:0], sub_ge};
         div_num_in = div_num_ff << 1;
         div_cnt_in = div_cnt_ff - 7'd1;
         if (div_cnt_ff == 7'd1) begin
            div_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff      <= 16'd10240;
         len_ff       <= 13'd64;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_busy_ff  <= 1'b0;
         div_busy_ff  <= 1'b0;
      end else begin
         beta_ff      <= beta_in;
         len_ff       <= len_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_busy_ff  <= mul_busy_in;
         div_busy_ff  <= div_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      x_ff        <= x_in;
      u_ff        <= u_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      i0_ff       <= i0_in;
      ix_ff       <= ix_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      second_ff   <= second_in;
      coef_ff     <= coef_in;
      err_ff      <= err_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_sh_ff   <= mul_sh_in;
      mul_acc_ff  <= mul_acc_in;
      mul_cnt_ff  <= mul_cnt_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      div_wrap_ff <= div_wrap_in;
   end

endmodule

### sv/kwc_checker.sv
// Port-level checker for the Kaiser window coefficient block, bound to the top level.
// Depends on kwc_pkg.
module kwc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [kwc_pkg::INDEX_W-1:0] req_sample_index,
   input logic                        rsp_valid,
   input logic [kwc_pkg::COEF_W-1:0]  rsp_coefficient,
   input logic                        rsp_index_error,
   input logic                        csr_we,
   input logic                        csr_index,
   input logic [kwc_pkg::BETA_W-1:0]  csr_wdata
);
   import kwc_pkg::*;

   // an accepted request either answers at once or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("request accepted but neither busy nor answered");

   // leaving busy always delivers the result
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_coefficient == '0)
      else $error("index error with nonzero coefficient");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coefficient <= COEF_ONE)
      else $error("coefficient above 1.0");

endmodule

bind kaiser_window_coefficient kwc_checker u_kwc_checker (.*);
